// ===== hw/rtl/jss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jss_pkg: shared types and constants of the joint solution selector
// Angle and weight formats, the register map and the front-to-back queue item.
// ----------------------------------------------------------------------------
package jss_pkg;

  localparam int unsigned JOINTS       = 6;
  localparam int unsigned ANGLE_W      = 16;
  localparam int unsigned WEIGHT_W     = 8;
  localparam int unsigned LIMIT_W      = 32;
  localparam int unsigned PROD_W       = ANGLE_W + WEIGHT_W;
  localparam int unsigned COST_W       = 27;
  localparam int unsigned WEIGHT_SET_W = JOINTS * WEIGHT_W;
  localparam int unsigned DATA_W       = 64;
  localparam int unsigned ADDR_W       = 6;
  localparam int unsigned REG_IDX_W    = 3;
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [COST_W-1:0]       COST_ONES     = '1;
  localparam logic [LIMIT_W-1:0]      LIMIT_RESET   = 32'h7FFF_8000;
  localparam logic [WEIGHT_SET_W-1:0] WEIGHT_RESET  = 48'h1010_1010_1010;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_LIMIT0  = 3'd0,
    REG_LIMIT1  = 3'd1,
    REG_LIMIT2  = 3'd2,
    REG_LIMIT3  = 3'd3,
    REG_LIMIT4  = 3'd4,
    REG_LIMIT5  = 3'd5,
    REG_WEIGHTS = 3'd6
  } reg_idx_e;

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic [LIMIT_W-1:0]        limit_t;

  typedef struct packed {
    limit_t [JOINTS-1:0]       limit;
    logic [WEIGHT_SET_W-1:0]   weights;
  } cfg_t;

  typedef struct packed {
    logic                is_load;
    logic                final_mark;
    logic                in_limits;
    logic [COST_W-1:0]   cost;
    angle_t [JOINTS-1:0] pose;
  } entry_t;

endpackage
`default_nettype wire

// ===== hw/rtl/jss_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jss_front: item intake and scoring
// Holds the current pose, applies the link adjustment, checks limits and
// forms the weighted L1 cost over two pipeline stages.
// ----------------------------------------------------------------------------
module jss_front (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  jss_pkg::cfg_t                          cfg_i,
  input  wire                                    in_valid_i,
  output logic                                   in_ready_o,
  input  wire                                    func_i,
  input  jss_pkg::angle_t [jss_pkg::JOINTS-1:0]  angle_i,
  input  wire                                    final_candidate_i,
  output logic                                   entry_valid_o,
  input  wire                                    entry_ready_i,
  output jss_pkg::entry_t                        entry_o
);
  import jss_pkg::*;

  angle_t [JOINTS-1:0]      cur_pose_q;
  angle_t [JOINTS-1:0]      adj;
  logic signed [ANGLE_W:0]  link_sum;
  angle_t                   link_sat;
  angle_t                   lim_lo [JOINTS];
  angle_t                   lim_hi [JOINTS];
  logic signed [ANGLE_W:0]  diff [JOINTS];
  logic signed [ANGLE_W:0]  diff_neg [JOINTS];
  logic [ANGLE_W-1:0]       absd [JOINTS];
  logic                     in_limits;
  logic                     accept;
  logic                     s1_ready;
  logic                     s2_ready;

  logic                     s1_v_q;
  logic                     s1_load_q;
  logic                     s1_final_q;
  logic                     s1_in_limits_q;
  angle_t [JOINTS-1:0]      s1_pose_q;
  logic [ANGLE_W-1:0]       s1_absd_q [JOINTS];

  logic                     s2_v_q;
  logic                     s2_load_q;
  logic                     s2_final_q;
  logic                     s2_in_limits_q;
  angle_t [JOINTS-1:0]      s2_pose_q;
  logic [PROD_W-1:0]        s2_prod_q [JOINTS];
  logic [PROD_W-1:0]        prod [JOINTS];
  logic [COST_W-1:0]        cost;

  assign s2_ready   = !s2_v_q || entry_ready_i;
  assign s1_ready   = !s1_v_q || s2_ready;
  assign in_ready_o = s1_ready;
  assign accept     = in_valid_i && s1_ready;

  // parallel link, saturating
  assign link_sum = {angle_i[1][ANGLE_W-1], angle_i[1]} + {angle_i[2][ANGLE_W-1], angle_i[2]};

  always_comb begin
    if (link_sum[ANGLE_W] != link_sum[ANGLE_W-1]) begin
      link_sat = link_sum[ANGLE_W] ? {1'b1, {(ANGLE_W-1){1'b0}}} : {1'b0, {(ANGLE_W-1){1'b1}}};
    end else begin
      link_sat = link_sum[ANGLE_W-1:0];
    end
  end

  always_comb begin
    adj = angle_i;
    if (func_i) begin
      adj[2] = link_sat;
    end
    in_limits = 1'b1;
    for (int k = 0; k < JOINTS; k++) begin
      lim_lo[k]   = cfg_i.limit[k][ANGLE_W-1:0];
      lim_hi[k]   = cfg_i.limit[k][LIMIT_W-1:ANGLE_W];
      if ($signed(adj[k]) < lim_lo[k] || $signed(adj[k]) > lim_hi[k]) begin
        in_limits = 1'b0;
      end
      diff[k]     = {adj[k][ANGLE_W-1], adj[k]} - {cur_pose_q[k][ANGLE_W-1], cur_pose_q[k]};
      diff_neg[k] = -diff[k];
      absd[k]     = diff[k][ANGLE_W] ? diff_neg[k][ANGLE_W-1:0] : diff[k][ANGLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_pose_q <= '0;
    end else if (accept && !func_i) begin
      cur_pose_q <= angle_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_v_q <= s1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_load_q      <= !func_i;
      s1_final_q     <= final_candidate_i;
      s1_in_limits_q <= in_limits;
      s1_pose_q      <= adj;
      for (int k = 0; k < JOINTS; k++) begin
        s1_absd_q[k] <= absd[k];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < JOINTS; k++) begin
      prod[k] = PROD_W'(s1_absd_q[k]) * PROD_W'(cfg_i.weights[k*WEIGHT_W +: WEIGHT_W]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_v_q) begin
      s2_load_q      <= s1_load_q;
      s2_final_q     <= s1_final_q;
      s2_in_limits_q <= s1_in_limits_q;
      s2_pose_q      <= s1_pose_q;
      for (int k = 0; k < JOINTS; k++) begin
        s2_prod_q[k] <= prod[k];
      end
    end
  end

  always_comb begin
    cost = '0;
    for (int k = 0; k < JOINTS; k++) begin
      cost = cost + COST_W'(s2_prod_q[k]);
    end
  end

  assign entry_valid_o       = s2_v_q;
  assign entry_o.is_load     = s2_load_q;
  assign entry_o.final_mark  = s2_final_q;
  assign entry_o.in_limits   = s2_in_limits_q;
  assign entry_o.cost        = cost;
  assign entry_o.pose        = s2_pose_q;

endmodule
`default_nettype wire

// ===== hw/rtl/jss_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jss_queue: short queue between front and back
// Register-based first-in first-out buffer of scored items.
// ----------------------------------------------------------------------------
module jss_queue (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_valid_i,
  output logic             push_ready_o,
  input  jss_pkg::entry_t  push_entry_i,
  output logic             pop_valid_o,
  input  wire              pop_ready_i,
  output jss_pkg::entry_t  pop_entry_o
);
  import jss_pkg::*;

  entry_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q;
  logic [QPTR_W-1:0]   rd_ptr_q;
  logic [QCNT_W-1:0]   count_q;
  logic                push;
  logic                pop;

  assign push_ready_o = count_q != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_entry_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/jss_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jss_back: running minimum and result register
// Keeps the best scored candidate of a query and emits it on the last one.
// ----------------------------------------------------------------------------
module jss_back (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    pop_valid_i,
  output logic                                   pop_ready_o,
  input  jss_pkg::entry_t                        entry_i,
  output logic                                   out_valid_o,
  input  wire                                    out_ready_i,
  output logic                                   found_o,
  output jss_pkg::angle_t [jss_pkg::JOINTS-1:0]  best_o
);
  import jss_pkg::*;

  logic                 have_best_q, have_best_d;
  logic [COST_W-1:0]    best_cost_q, best_cost_d;
  angle_t [JOINTS-1:0]  best_pose_q, best_pose_d;
  logic                 out_v_q, out_v_d;
  logic                 found_q, found_d;
  angle_t [JOINTS-1:0]  out_pose_q, out_pose_d;
  logic                 take;
  logic                 better;
  logic                 upd_have;
  logic [COST_W-1:0]    upd_cost;
  angle_t [JOINTS-1:0]  upd_pose;

  assign pop_ready_o = !out_v_q || out_ready_i;
  assign take        = pop_valid_i && pop_ready_o;

  always_comb begin
    better   = entry_i.in_limits && (entry_i.cost < best_cost_q);
    upd_have = have_best_q || better;
    upd_cost = better ? entry_i.cost : best_cost_q;
    upd_pose = better ? entry_i.pose : best_pose_q;

    have_best_d = have_best_q;
    best_cost_d = best_cost_q;
    best_pose_d = best_pose_q;
    out_v_d     = out_v_q && !out_ready_i;
    found_d     = found_q;
    out_pose_d  = out_pose_q;

    if (take) begin
      priority if (entry_i.is_load) begin
        have_best_d = 1'b0;
        best_cost_d = COST_ONES;
        best_pose_d = '0;
      end else if (entry_i.final_mark) begin
        out_v_d     = 1'b1;
        found_d     = upd_have;
        out_pose_d  = upd_have ? upd_pose : '0;
        have_best_d = 1'b0;
        best_cost_d = COST_ONES;
        best_pose_d = '0;
      end else begin
        have_best_d = upd_have;
        best_cost_d = upd_cost;
        best_pose_d = upd_pose;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_best_q <= 1'b0;
      best_cost_q <= COST_ONES;
      best_pose_q <= '0;
      out_v_q     <= 1'b0;
    end else begin
      have_best_q <= have_best_d;
      best_cost_q <= best_cost_d;
      best_pose_q <= best_pose_d;
      out_v_q     <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q    <= found_d;
    out_pose_q <= out_pose_d;
  end

  assign out_valid_o = out_v_q;
  assign found_o     = found_q;
  assign best_o      = out_pose_q;

  a_empty_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> best_o == '0)
    else $error("empty query result carries a nonzero pose");

  a_cost_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !have_best_q |-> best_cost_q == COST_ONES)
    else $error("best cost set without a kept candidate");

  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && !entry_i.is_load && entry_i.final_mark |=> !have_best_q && out_valid_o)
    else $error("last candidate did not give a result and clear the best");

  a_load_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && entry_i.is_load |=> !have_best_q)
    else $error("load did not clear the running best");

endmodule
`default_nettype wire

// ===== hw/rtl/joint_solution_selector_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// joint_solution_selector_top: best six-joint candidate by weighted L1 cost
// Input channel (in_valid_i/in_ready_o): a load item (func_i=0) sets the
// current pose and clears the running best; a candidate item (func_i=1) is
// link-adjusted, limit-checked and scored. A candidate with
// final_candidate_i=1 gives one result item on the output channel
// (out_valid_o/out_ready_i): found_o and the kept pose, all zero if none.
// Throughput is one item per cycle while out_ready_i is high; the front scores in
// two register stages, a two-entry queue decouples it from the back, whose
// running-minimum compare feeds the result register behind out_valid_o.
// A stalled receiver holds the result register; the back stops, the queue
// fills, and in_ready_o falls once the front stages are full too.
// Reset sets the limits to admit every angle, all weights to 0x10, the
// current pose to zero and clears the running best.
// Registers on the APB port: limit_joint0..5 at 0x00..0x28, weights at 0x30.
// ----------------------------------------------------------------------------
module joint_solution_selector_top (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire [jss_pkg::ADDR_W-1:0]        paddr,
  input  wire [jss_pkg::DATA_W-1:0]        pwdata,
  output logic [jss_pkg::DATA_W-1:0]       prdata,
  output logic                             pready,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire                              func_i,
  input  wire signed [jss_pkg::ANGLE_W-1:0] angle_a_i,
  input  wire signed [jss_pkg::ANGLE_W-1:0] angle_b_i,
  input  wire signed [jss_pkg::ANGLE_W-1:0] angle_c_i,
  input  wire signed [jss_pkg::ANGLE_W-1:0] angle_d_i,
  input  wire signed [jss_pkg::ANGLE_W-1:0] angle_e_i,
  input  wire signed [jss_pkg::ANGLE_W-1:0] angle_f_i,
  input  wire                              final_candidate_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic                             found_o,
  output logic signed [jss_pkg::ANGLE_W-1:0] best_a_o,
  output logic signed [jss_pkg::ANGLE_W-1:0] best_b_o,
  output logic signed [jss_pkg::ANGLE_W-1:0] best_c_o,
  output logic signed [jss_pkg::ANGLE_W-1:0] best_d_o,
  output logic signed [jss_pkg::ANGLE_W-1:0] best_e_o,
  output logic signed [jss_pkg::ANGLE_W-1:0] best_f_o
);
  import jss_pkg::*;

  limit_t [JOINTS-1:0]      limit_q;
  logic [WEIGHT_SET_W-1:0]  weights_q;
  reg_idx_e                 reg_idx;
  logic                     wr_en;
  cfg_t                     cfg;
  angle_t [JOINTS-1:0]      angle_in;
  angle_t [JOINTS-1:0]      best_out;
  logic                     entry_valid;
  logic                     entry_ready;
  entry_t                   entry_push;
  logic                     pop_valid;
  logic                     pop_ready;
  entry_t                   entry_pop;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[ADDR_W-1:ADDR_W-REG_IDX_W]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < JOINTS; k++) begin
        limit_q[k] <= LIMIT_RESET;
      end
      weights_q <= WEIGHT_RESET;
    end else if (wr_en) begin
      priority if (reg_idx <= REG_LIMIT5) begin
        limit_q[reg_idx] <= pwdata[LIMIT_W-1:0];
      end else if (reg_idx == REG_WEIGHTS) begin
        weights_q <= pwdata[WEIGHT_SET_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    priority if (reg_idx <= REG_LIMIT5) begin
      prdata = DATA_W'(limit_q[reg_idx]);
    end else if (reg_idx == REG_WEIGHTS) begin
      prdata = DATA_W'(weights_q);
    end
  end

  assign cfg.limit   = limit_q;
  assign cfg.weights = weights_q;

  assign angle_in[0] = angle_a_i;
  assign angle_in[1] = angle_b_i;
  assign angle_in[2] = angle_c_i;
  assign angle_in[3] = angle_d_i;
  assign angle_in[4] = angle_e_i;
  assign angle_in[5] = angle_f_i;

  jss_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .func_i            (func_i),
    .angle_i           (angle_in),
    .final_candidate_i (final_candidate_i),
    .entry_valid_o     (entry_valid),
    .entry_ready_i     (entry_ready),
    .entry_o           (entry_push)
  );

  jss_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (entry_valid),
    .push_ready_o (entry_ready),
    .push_entry_i (entry_push),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (entry_pop)
  );

  jss_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .entry_i     (entry_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .found_o     (found_o),
    .best_o      (best_out)
  );

  assign best_a_o = best_out[0];
  assign best_b_o = best_out[1];
  assign best_c_o = best_out[2];
  assign best_d_o = best_out[3];
  assign best_e_o = best_out[4];
  assign best_f_o = best_out[5];

endmodule
`default_nettype wire
